### rtl/core/bsab_pkg.sv
// Shared constants, types and arithmetic helpers of the bilinear scale and blend block.
package bsab_pkg;

    // Default image limits
    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;

    // Item opcodes
    localparam logic [1:0] OP_WRITE_A = 2'd0;
    localparam logic [1:0] OP_WRITE_B = 2'd1;
    localparam logic [1:0] OP_SAMPLE  = 2'd2;

    // Configuration register indexes (byte address = 4 * index)
    localparam int         PADDR_W       = 5;
    localparam logic [2:0] REG_SCALE_X_A = 3'd0;
    localparam logic [2:0] REG_SCALE_Y_A = 3'd1;
    localparam logic [2:0] REG_SCALE_X_B = 3'd2;
    localparam logic [2:0] REG_SCALE_Y_B = 3'd3;
    localparam logic [2:0] REG_BLEND     = 3'd4;

    // Q.16 constants
    localparam logic [16:0] Q16_ONE  = 17'h10000;
    localparam logic [16:0] Q16_HALF = 17'h08000;

    typedef logic [23:0] t_pixel;
    typedef logic [16:0] t_q16;

    // Weighted mix of two 8-bit values, truncated: (a*(1-w) + b*w) >> 16
    function automatic logic [7:0] lerp_q16(input logic [7:0] a, input logic [7:0] b,
                                            input t_q16 w);
        logic [16:0] wi;
        logic [24:0] sum;
        wi  = Q16_ONE - w;
        sum = 25'(a) * 25'(wi) + 25'(b) * 25'(w);
        return sum[23:16];
    endfunction

endpackage

### rtl/core/bilinear_scale_alpha_blend_top.sv
// Top level of the bilinear resample and alpha blend block for two RGB888 images.
//
// Usage:
//   An item is taken at a clock edge where start is high and busy is low.
//   Opcode 0 / 1 writes one pixel of image A / B; opcode 2 samples the
//   blended output pixel at (column, row); opcode 3 is dropped.
//   A write does not raise busy: a new item may follow in the next cycle.
//   A sample holds busy so that later items cannot claim the memory ports
//   during its four neighbor reads through the single port of each pixel
//   memory (both images are read in parallel).
//   The blended word appears on o_red_out, o_green_out, o_blue_out with
//   o_valid high for exactly one cycle, once the sample has passed stage 1,
//   stage 2, the read phases in r_ph and the output register.
//   The receiver cannot stall; every word must be taken in its cycle.
//   Writes pass through stage 1 and stage 2 before they land in memory, so a
//   sample that follows a write always sees it.
//   Scale and blend registers sit on the APB port at 4*index; the user must
//   write them only while the block is idle, as the block itself does not check this. pready is always high.
//   Reset clears the registers to pass-through scale and half blend and
//   empties the pipeline; pixel memories are not cleared and hold
//   undefined data until written.
module bilinear_scale_alpha_blend_top #(
    parameter int MAX_WIDTH  = bsab_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bsab_pkg::DEF_MAX_HEIGHT
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Item channel
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   i_opcode,
    input  logic [7:0]                   i_column,
    input  logic [7:0]                   i_row,
    input  logic [7:0]                   i_red_in,
    input  logic [7:0]                   i_green_in,
    input  logic [7:0]                   i_blue_in,
    // Result channel
    output logic                         o_valid,
    output logic [7:0]                   o_red_out,
    output logic [7:0]                   o_green_out,
    output logic [7:0]                   o_blue_out,
    // Configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bsab_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    import bsab_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);

    localparam logic [AW-1:0] ROW_PITCH   = AW'(MAX_WIDTH);
    localparam logic [15:0]   LAST_COL    = 16'(MAX_WIDTH - 1);
    localparam logic [15:0]   LAST_ROW    = 16'(MAX_HEIGHT - 1);
    localparam logic [1:0]    SAMPLE_HOLD = 2'd3;

    // Configuration registers, indexed by image (0 = A, 1 = B)
    t_q16 r_scale_x [2];
    t_q16 r_scale_y [2];
    t_q16 r_blend;

    // Control
    logic       accept;
    logic       cfg_wr;
    logic [1:0] r_busy_cnt;
    logic       r_s1_v;
    logic       r_s2_smp;
    logic [1:0] r_s2_we;
    logic [6:1] r_ph;
    logic       r_out_v;

    // Stage 1: scaled coordinates and write data
    logic [1:0]  r_s1_op;
    logic [7:0]  r_s1_col;
    logic [7:0]  r_s1_row;
    t_pixel      r_s1_pix;
    logic [24:0] r_s1_px [2];
    logic [24:0] r_s1_py [2];

    // Stage 2: neighbor indices, fractions, write address
    logic [XW-1:0] r_s2_x0 [2];
    logic [XW-1:0] r_s2_x1 [2];
    logic [YW-1:0] r_s2_y0 [2];
    logic [YW-1:0] r_s2_y1 [2];
    t_q16          r_s2_fx [2];
    t_q16          r_s2_fy [2];
    logic [AW-1:0] r_s2_waddr;
    t_pixel        r_s2_wpix;

    // Interpolation pipeline
    t_q16   r_ctx_fx [2];
    t_q16   r_ctx_fy [2];
    t_q16   r_h_fx   [2];
    t_pixel r_p00    [2];
    t_pixel r_p10    [2];
    t_pixel r_left   [2];
    t_pixel r_right  [2];
    t_pixel r_c      [2];
    t_pixel r_out;

    // Combinational
    logic [XW-1:0] n_x0 [2];
    logic [XW-1:0] n_x1 [2];
    logic [YW-1:0] n_y0 [2];
    logic [YW-1:0] n_y1 [2];
    t_q16          n_fx [2];
    t_q16          n_fy [2];
    logic [AW-1:0] n_waddr;
    logic [1:0]    n_we;
    logic [AW-1:0] ram_addr  [2];
    t_pixel        ram_rdata [2];
    t_pixel        n_left    [2];
    t_pixel        n_right   [2];
    t_pixel        n_c       [2];
    t_pixel        n_out;
    t_q16          ratio;

    assign busy   = (r_busy_cnt != 2'd0);
    assign accept = start && !busy;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    // Clamp a neighbor index to the last column or row
    function automatic logic [15:0] clamp_idx(input logic [15:0] idx, input logic [15:0] last);
        return (idx > last) ? last : idx;
    endfunction

    // Decode register reads
    always_comb begin
        unique case (paddr[4:2])
            REG_SCALE_X_A: prdata = 32'(r_scale_x[0]);
            REG_SCALE_Y_A: prdata = 32'(r_scale_y[0]);
            REG_SCALE_X_B: prdata = 32'(r_scale_x[1]);
            REG_SCALE_Y_B: prdata = 32'(r_scale_y[1]);
            REG_BLEND:     prdata = 32'(r_blend);
            default:       prdata = 32'd0;
        endcase
    end

    // Work out neighbor indices and the write target from stage 1
    always_comb begin
        logic [15:0] i0;
        logic [15:0] i1;
        for (int img = 0; img < 2; img++) begin
            i0        = 16'(r_s1_px[img][24:16]);
            i1        = i0 + 16'(r_s1_px[img][15:0] != 16'd0);
            i0        = clamp_idx(i0, LAST_COL);
            i1        = clamp_idx(i1, LAST_COL);
            n_x0[img] = i0[XW-1:0];
            n_x1[img] = i1[XW-1:0];
            n_fx[img] = {1'b0, r_s1_px[img][15:0]};

            i0        = 16'(r_s1_py[img][24:16]);
            i1        = i0 + 16'(r_s1_py[img][15:0] != 16'd0);
            i0        = clamp_idx(i0, LAST_ROW);
            i1        = clamp_idx(i1, LAST_ROW);
            n_y0[img] = i0[YW-1:0];
            n_y1[img] = i1[YW-1:0];
            n_fy[img] = {1'b0, r_s1_py[img][15:0]};
        end
        n_waddr = AW'(r_s1_row) * ROW_PITCH + AW'(r_s1_col);
        n_we[0] = r_s1_v && (r_s1_op == OP_WRITE_A) &&
                  (16'(r_s1_col) <= LAST_COL) && (16'(r_s1_row) <= LAST_ROW);
        n_we[1] = r_s1_v && (r_s1_op == OP_WRITE_B) &&
                  (16'(r_s1_col) <= LAST_COL) && (16'(r_s1_row) <= LAST_ROW);
    end

    // Steer memory addresses: four neighbor reads, else the pending write
    always_comb begin
        logic [YW-1:0] ry;
        logic [XW-1:0] rx;
        for (int img = 0; img < 2; img++) begin
            ry = (r_s2_smp || r_ph[2]) ? r_s2_y0[img] : r_s2_y1[img];
            rx = (r_s2_smp || r_ph[1]) ? r_s2_x0[img] : r_s2_x1[img];
            if (r_s2_smp || (|r_ph[3:1])) begin
                ram_addr[img] = AW'(ry) * ROW_PITCH + AW'(rx);
            end else begin
                ram_addr[img] = r_s2_waddr;
            end
        end
    end

    // Pixel memories
    for (genvar g = 0; g < 2; g++) begin : g_store
        bsab_ram #(
            .WIDTH (24),
            .DEPTH (DEPTH)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (r_s2_we[g]),
            .i_addr  (ram_addr[g]),
            .i_wdata (r_s2_wpix),
            .o_rdata (ram_rdata[g])
        );
    end

    // Interpolate vertically, then horizontally, then blend the two images
    always_comb begin
        ratio = (r_blend > Q16_ONE) ? Q16_ONE : r_blend;
        for (int img = 0; img < 2; img++) begin
            for (int ch = 0; ch < 3; ch++) begin
                n_left[img][8*ch +: 8]  = lerp_q16(r_p00[img][8*ch +: 8],
                                                   ram_rdata[img][8*ch +: 8], r_ctx_fy[img]);
                n_right[img][8*ch +: 8] = lerp_q16(r_p10[img][8*ch +: 8],
                                                   ram_rdata[img][8*ch +: 8], r_ctx_fy[img]);
                n_c[img][8*ch +: 8]     = lerp_q16(r_left[img][8*ch +: 8],
                                                   r_right[img][8*ch +: 8], r_h_fx[img]);
            end
        end
        for (int ch = 0; ch < 3; ch++) begin
            n_out[8*ch +: 8] = lerp_q16(r_c[1][8*ch +: 8], r_c[0][8*ch +: 8], ratio);
        end
    end

    // Control state and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy_cnt   <= 2'd0;
            r_s1_v       <= 1'b0;
            r_s2_smp     <= 1'b0;
            r_s2_we      <= 2'b00;
            r_ph         <= '0;
            r_out_v      <= 1'b0;
            r_scale_x[0] <= Q16_ONE;
            r_scale_y[0] <= Q16_ONE;
            r_scale_x[1] <= Q16_ONE;
            r_scale_y[1] <= Q16_ONE;
            r_blend      <= Q16_HALF;
        end else begin
            // Hold off new items while the memory ports are claimed
            if (accept && (i_opcode == OP_SAMPLE)) begin
                r_busy_cnt <= SAMPLE_HOLD;
            end else if (busy) begin
                r_busy_cnt <= r_busy_cnt - 2'd1;
            end
            r_s1_v   <= accept;
            r_s2_smp <= r_s1_v && (r_s1_op == OP_SAMPLE);
            r_s2_we  <= n_we;
            r_ph     <= {r_ph[5:1], r_s2_smp};
            r_out_v  <= r_ph[6];
            if (cfg_wr) begin
                unique case (paddr[4:2])
                    REG_SCALE_X_A: r_scale_x[0] <= pwdata[16:0];
                    REG_SCALE_Y_A: r_scale_y[0] <= pwdata[16:0];
                    REG_SCALE_X_B: r_scale_x[1] <= pwdata[16:0];
                    REG_SCALE_Y_B: r_scale_y[1] <= pwdata[16:0];
                    REG_BLEND:     r_blend      <= pwdata[16:0];
                    default: ;
                endcase
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        // Capture the item and scale its coordinate for both images
        if (accept) begin
            r_s1_op  <= i_opcode;
            r_s1_col <= i_column;
            r_s1_row <= i_row;
            r_s1_pix <= {i_red_in, i_green_in, i_blue_in};
            for (int img = 0; img < 2; img++) begin
                r_s1_px[img] <= 25'(i_column) * 25'(r_scale_x[img]);
                r_s1_py[img] <= 25'(i_row) * 25'(r_scale_y[img]);
            end
        end
        if (r_s1_v) begin
            r_s2_x0    <= n_x0;
            r_s2_x1    <= n_x1;
            r_s2_y0    <= n_y0;
            r_s2_y1    <= n_y1;
            r_s2_fx    <= n_fx;
            r_s2_fy    <= n_fy;
            r_s2_waddr <= n_waddr;
            r_s2_wpix  <= r_s1_pix;
        end
        // Carry fractions along with the reads
        if (r_s2_smp) begin
            r_ctx_fx <= r_s2_fx;
            r_ctx_fy <= r_s2_fy;
        end
        if (r_ph[1]) begin
            r_p00 <= ram_rdata;
        end
        if (r_ph[2]) begin
            r_left <= n_left;
        end
        if (r_ph[3]) begin
            r_p10 <= ram_rdata;
        end
        if (r_ph[4]) begin
            r_right <= n_right;
            r_h_fx  <= r_ctx_fx;
        end
        if (r_ph[5]) begin
            r_c <= n_c;
        end
        if (r_ph[6]) begin
            r_out <= n_out;
        end
    end

    assign o_valid     = r_out_v;
    assign o_red_out   = r_out[23:16];
    assign o_green_out = r_out[15:8];
    assign o_blue_out  = r_out[7:0];

    // A pending write never lands in a neighbor read slot
    a_no_port_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !((|r_s2_we) && (r_s2_smp || (|r_ph[3:1]))))
        else $error("pixel write collides with a neighbor read");

    // A taken sample is followed by its result word on o_valid
    a_sample_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_opcode == OP_SAMPLE)) |-> ##9 o_valid)
        else $error("sample word missing at expected latency");

    // Result words are single-cycle strobes
    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held for more than one cycle");

    // A sample in stage 1 keeps busy high to hold new items out
    a_busy_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_v && (r_s1_op == OP_SAMPLE)) |-> busy ##1 busy ##1 busy)
        else $error("busy dropped during neighbor reads");

endmodule

### rtl/core/bsab_ram.sv
// Generic single-port RAM with registered read data.
module bsab_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write on enable, read every cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

### tb/testbench.sv
// Self-checking bench for the bilinear scale and alpha blend block: pixel writes, samples, APB setup.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import bsab_pkg::*;

    localparam logic [1:0] OP_UNUSED      = 2'd3;
    localparam int         SETTLE_CYCLES  = 12;
    localparam int         WATCHDOG_LIMIT = 5000;
    localparam int         RANDOM_PHASES  = 6;
    localparam int         PHASE_OPS      = 200;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] column;
        logic [7:0] row;
        t_pixel     color;
    } t_pixel_op;

    // Block inputs, all known from time zero
    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 start       = 1'b0;
    logic [1:0]           i_opcode    = 2'd0;
    logic [7:0]           i_column    = 8'd0;
    logic [7:0]           i_row       = 8'd0;
    logic [7:0]           i_red_in    = 8'd0;
    logic [7:0]           i_green_in  = 8'd0;
    logic [7:0]           i_blue_in   = 8'd0;
    logic                 psel        = 1'b0;
    logic                 penable     = 1'b0;
    logic                 pwrite      = 1'b0;
    logic [PADDR_W-1:0]   paddr       = '0;
    logic [31:0]          pwdata      = 32'd0;

    logic                 busy;
    logic                 o_valid;
    logic [7:0]           o_red_out;
    logic [7:0]           o_green_out;
    logic [7:0]           o_blue_out;
    logic [31:0]          prdata;
    logic                 pready;

    // Shadow copies of the images and registers
    t_pixel      image_a [65536];
    t_pixel      image_b [65536];
    bit          filled_a [65536];
    bit          filled_b [65536];
    t_q16        reg_value [5];

    t_pixel_op   pixel_ops [$];
    t_pixel      blended_due [$];
    t_pixel_op   next_op;
    int unsigned ops_issued  = 0;
    int unsigned ops_taken   = 0;
    int unsigned useful_ops  = 0;
    int unsigned mismatches  = 0;
    int unsigned quiet       = 0;
    int          idle_pct    = 6;
    string       channel_name [3] = '{"blue", "green", "red"};

    bilinear_scale_alpha_blend_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_opcode    (i_opcode),
        .i_column    (i_column),
        .i_row       (i_row),
        .i_red_in    (i_red_in),
        .i_green_in  (i_green_in),
        .i_blue_in   (i_blue_in),
        .o_valid     (o_valid),
        .o_red_out   (o_red_out),
        .o_green_out (o_green_out),
        .o_blue_out  (o_blue_out),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Weighted mix (a*(1-w) + b*w) >> 16, truncated
    function automatic logic [7:0] weigh(input logic [7:0] a, input logic [7:0] b,
                                         input t_q16 w);
        logic [25:0] acc;
        acc = 26'(a) * 26'(Q16_ONE - w) + 26'(b) * 26'(w);
        return acc[23:16];
    endfunction

    // Scale one coordinate, return both neighbor indices (clamped) and the fraction
    function automatic void locate(input logic [7:0] coord, input t_q16 scale,
                                   output logic [7:0] lo, output logic [7:0] hi,
                                   output t_q16 frac);
        logic [24:0] prod;
        logic [9:0]  i0;
        logic [9:0]  i1;
        prod = 25'(coord) * 25'(scale);
        i0   = {1'b0, prod[24:16]};
        frac = {1'b0, prod[15:0]};
        i1   = i0 + ((prod[15:0] != 16'd0) ? 10'd1 : 10'd0);
        lo   = (i0 > 10'd255) ? 8'd255 : i0[7:0];
        hi   = (i1 > 10'd255) ? 8'd255 : i1[7:0];
    endfunction

    // Bilinear sample of one image: vertical pass, then horizontal
    function automatic t_pixel resample(input bit from_b, input logic [7:0] col,
                                        input logic [7:0] row);
        logic [7:0] x0, x1, y0, y1, left, right;
        t_q16       fx, fy;
        t_pixel     n00, n01, n10, n11, rgb;
        int         k;
        locate(col, from_b ? reg_value[REG_SCALE_X_B] : reg_value[REG_SCALE_X_A], x0, x1, fx);
        locate(row, from_b ? reg_value[REG_SCALE_Y_B] : reg_value[REG_SCALE_Y_A], y0, y1, fy);
        n00 = from_b ? image_b[{y0, x0}] : image_a[{y0, x0}];
        n01 = from_b ? image_b[{y1, x0}] : image_a[{y1, x0}];
        n10 = from_b ? image_b[{y0, x1}] : image_a[{y0, x1}];
        n11 = from_b ? image_b[{y1, x1}] : image_a[{y1, x1}];
        for (k = 0; k < 3; k++) begin
            left           = weigh(n00[8*k +: 8], n01[8*k +: 8], fy);
            right          = weigh(n10[8*k +: 8], n11[8*k +: 8], fy);
            rgb[8*k +: 8]  = weigh(left, right, fx);
        end
        return rgb;
    endfunction

    // Blended color at an output coordinate; ratio above one saturates
    function automatic t_pixel blend_at(input logic [7:0] col, input logic [7:0] row);
        t_pixel from_a, from_b, blended;
        t_q16   ratio;
        int     k;
        from_a = resample(1'b0, col, row);
        from_b = resample(1'b1, col, row);
        ratio  = (reg_value[REG_BLEND] > Q16_ONE) ? Q16_ONE : reg_value[REG_BLEND];
        for (k = 0; k < 3; k++) begin
            blended[8*k +: 8] = weigh(from_b[8*k +: 8], from_a[8*k +: 8], ratio);
        end
        return blended;
    endfunction

    // Update the shadow images or expect a blended word
    task automatic apply_op(input t_pixel_op op);
        case (op.opcode)
            OP_WRITE_A: image_a[{op.row, op.column}] = op.color;
            OP_WRITE_B: image_b[{op.row, op.column}] = op.color;
            OP_SAMPLE:  blended_due.push_back(blend_at(op.column, op.row));
            default: ;
        endcase
    endtask

    task automatic queue_op(input logic [1:0] opcode, input logic [7:0] col,
                            input logic [7:0] row, input t_pixel color);
        pixel_ops.push_back(t_pixel_op'{opcode, col, row, color});
        ops_issued++;
        if (opcode == OP_WRITE_A) filled_a[{row, col}] = 1'b1;
        if (opcode == OP_WRITE_B) filled_b[{row, col}] = 1'b1;
        if (opcode != OP_UNUSED) useful_ops++;
    endtask

    task automatic fill_if_blank(input bit to_b, input logic [7:0] col, input logic [7:0] row);
        if (to_b ? !filled_b[{row, col}] : !filled_a[{row, col}]) begin
            queue_op(to_b ? OP_WRITE_B : OP_WRITE_A, col, row, t_pixel'($urandom));
        end
    endtask

    // Write any neighbor not yet written in either image, then sample
    task automatic queue_sample(input logic [7:0] col, input logic [7:0] row);
        logic [7:0] x0, x1, y0, y1;
        t_q16       fx, fy;
        int         s;
        for (s = 0; s < 2; s++) begin
            locate(col, (s != 0) ? reg_value[REG_SCALE_X_B] : reg_value[REG_SCALE_X_A],
                   x0, x1, fx);
            locate(row, (s != 0) ? reg_value[REG_SCALE_Y_B] : reg_value[REG_SCALE_Y_A],
                   y0, y1, fy);
            fill_if_blank(s != 0, x0, y0);
            fill_if_blank(s != 0, x0, y1);
            fill_if_blank(s != 0, x1, y0);
            fill_if_blank(s != 0, x1, y1);
        end
        queue_op(OP_SAMPLE, col, row, t_pixel'($urandom));
    endtask

    // Favor the image corners so neighbors get reused
    function automatic logic [7:0] pick_coord();
        logic [7:0] c;
        case ($urandom_range(0, 3))
            0:       c = 8'($urandom_range(0, 7));
            1:       c = 8'($urandom_range(248, 255));
            default: c = 8'($urandom_range(0, 255));
        endcase
        return c;
    endfunction

    function automatic t_q16 pick_setting();
        t_q16 v;
        case ($urandom_range(0, 5))
            0:       v = 17'd0;
            1:       v = Q16_ONE;
            4:       v = t_q16'($urandom_range(1, 2048));
            5:       v = t_q16'($urandom_range(65537, 131071));
            default: v = t_q16'($urandom_range(0, 65536));
        endcase
        return v;
    endfunction

    // APB write: setup cycle, then access cycle
    task automatic write_register(input logic [2:0] index, input t_q16 value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        reg_value[index] = value;
    endtask

    // Wait until every word is taken and every result is back, then let writes land
    task automatic settle();
        while (ops_taken != ops_issued || blended_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Driver: predict the word taken at this edge, then load the next or idle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                apply_op(t_pixel_op'{i_opcode, i_column, i_row,
                                     {i_red_in, i_green_in, i_blue_in}});
                ops_taken++;
            end
            if (!start || !busy) begin
                if (pixel_ops.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
                    next_op    = pixel_ops.pop_front();
                    i_opcode   <= next_op.opcode;
                    i_column   <= next_op.column;
                    i_row      <= next_op.row;
                    i_red_in   <= next_op.color[23:16];
                    i_green_in <= next_op.color[15:8];
                    i_blue_in  <= next_op.color[7:0];
                    start      <= 1'b1;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each result word with the oldest expected color
    always @(posedge i_clk) begin
        t_pixel want;
        t_pixel got;
        if (i_rst_n && o_valid === 1'b1) begin
            got = {o_red_out, o_green_out, o_blue_out};
            if (blended_due.size() == 0) begin
                $display("%0t: result %h with none expected", $time, got);
                mismatches++;
            end else begin
                want = blended_due.pop_front();
                for (int k = 0; k < 3; k++) begin
                    if (got[8*k +: 8] !== want[8*k +: 8]) begin
                        $display("%0t: %s expected %02h got %02h", $time, channel_name[k],
                                 want[8*k +: 8], got[8*k +: 8]);
                        mismatches++;
                    end
                end
            end
        end
    end

    // Watchdog on cycles with no traffic at all
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid === 1'b1 || psel) begin
            quiet = 0;
        end else begin
            quiet = quiet + 1;
        end
        if (quiet >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        int unsigned goal;
        int          phase;
        int          roll;
        reg_value[REG_SCALE_X_A] = Q16_ONE;
        reg_value[REG_SCALE_Y_A] = Q16_ONE;
        reg_value[REG_SCALE_X_B] = Q16_ONE;
        reg_value[REG_SCALE_Y_B] = Q16_ONE;
        reg_value[REG_BLEND]     = Q16_HALF;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: color extremes at opposite corners, unused opcode dropped
        queue_op(OP_WRITE_A, 8'd0, 8'd0, 24'h000000);
        queue_op(OP_WRITE_B, 8'd0, 8'd0, 24'hFFFFFF);
        queue_sample(8'd0, 8'd0);
        queue_op(OP_WRITE_A, 8'd255, 8'd255, 24'hFFFFFF);
        queue_op(OP_WRITE_B, 8'd255, 8'd255, 24'h000000);
        queue_sample(8'd255, 8'd255);
        queue_op(OP_UNUSED, 8'd255, 8'd255, 24'hFFFFFF);
        queue_sample(8'd0, 8'd0);
        settle();

        // Fractional scales, full weight on image A
        write_register(REG_SCALE_X_A, Q16_HALF);
        write_register(REG_SCALE_Y_A, 17'hC000);
        write_register(REG_SCALE_X_B, 17'hFFFF);
        write_register(REG_SCALE_Y_B, 17'd1);
        write_register(REG_BLEND, Q16_ONE);
        queue_sample(8'd255, 8'd255);
        queue_sample(8'd1, 8'd3);
        settle();

        // Scales past one clamp the neighbors; zero scale and zero weight
        write_register(REG_SCALE_X_A, 17'h1FFFF);
        write_register(REG_SCALE_Y_A, 17'h10001);
        write_register(REG_SCALE_X_B, 17'd0);
        write_register(REG_SCALE_Y_B, 17'd0);
        write_register(REG_BLEND, 17'd0);
        queue_sample(8'd255, 8'd255);
        queue_sample(8'd200, 8'd130);
        settle();

        // Ratio above one saturates
        write_register(REG_BLEND, 17'h1FFFF);
        queue_sample(8'd255, 8'd255);
        queue_sample(8'd3, 8'd250);
        settle();

        // Random phases, each under fresh settings
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            idle_pct = (phase < 2) ? 6 : (phase < 4) ? 55 : 0;
            write_register(REG_SCALE_X_A, pick_setting());
            write_register(REG_SCALE_Y_A, pick_setting());
            write_register(REG_SCALE_X_B, pick_setting());
            write_register(REG_SCALE_Y_B, pick_setting());
            write_register(REG_BLEND, pick_setting());
            goal = useful_ops + PHASE_OPS;
            while (useful_ops < goal) begin
                roll = $urandom_range(0, 99);
                if (roll < 45) begin
                    queue_sample(pick_coord(), pick_coord());
                end else if (roll < 90) begin
                    queue_op(roll[0] ? OP_WRITE_B : OP_WRITE_A, pick_coord(), pick_coord(),
                             t_pixel'($urandom));
                end else begin
                    queue_op(OP_UNUSED, 8'($urandom), 8'($urandom), t_pixel'($urandom));
                end
            end
            settle();
        end

        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
